>>> rtl/aes_pkg.sv
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    typedef logic [7:0]   byte_t;
    typedef logic [127:0] block_t;

    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] MSB_BIT = 8'h80;

    localparam byte_t FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam byte_t RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic byte_t get_byte(input block_t b, input int i);
        get_byte = b[127 - 8*i -: 8];
    endfunction

    function automatic byte_t xtime(input byte_t x);
        xtime = (x & MSB_BIT) != 8'h00 ? ((x << 1) ^ GF_POLY) : (x << 1);
    endfunction

    function automatic byte_t gf_mul(input byte_t x, input logic [3:0] y);
        byte_t acc;
        byte_t p;
        acc = 8'h00;
        p = x;
        for (int i = 0; i < 4; i++)
        begin
            if (y[i])
                acc = acc ^ p;
            p = xtime(p);
        end
        gf_mul = acc;
    endfunction

    function automatic block_t sub_bytes(input block_t s, input logic inv);
        block_t t;
        for (int i = 0; i < 16; i++)
            t[127 - 8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : FWD_SBOX[get_byte(s, i)];
        sub_bytes = t;
    endfunction

    function automatic block_t shift_rows(input block_t s, input logic inv);
        block_t t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[127 - 8*(r + 4*c) -: 8] = get_byte(s, r + 4*src);
            end
        shift_rows = t;
    endfunction

    function automatic block_t mix_columns(input block_t s, input logic inv);
        block_t t;
        logic [3:0] m [4];
        byte_t acc;
        if (inv)
            m = '{4'd14, 4'd11, 4'd13, 4'd9};
        else
            m = '{4'd2, 4'd3, 4'd1, 4'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc = acc ^ gf_mul(get_byte(s, 4*c + j), m[(j - r + 4) & 3]);
                t[127 - 8*(4*c + r) -: 8] = acc;
            end
        mix_columns = t;
    endfunction

    function automatic block_t next_round_key(input block_t k, input byte_t rc);
        block_t n;
        byte_t tw [4];
        tw[0] = FWD_SBOX[get_byte(k, 13)] ^ rc;
        tw[1] = FWD_SBOX[get_byte(k, 14)];
        tw[2] = FWD_SBOX[get_byte(k, 15)];
        tw[3] = FWD_SBOX[get_byte(k, 12)];
        for (int j = 0; j < 4; j++)
            n[127 - 8*j -: 8] = get_byte(k, j) ^ tw[j];
        for (int j = 4; j < 16; j++)
            n[127 - 8*j -: 8] = get_byte(k, j) ^ n[127 - 8*(j-4) -: 8];
        next_round_key = n;
    endfunction

endpackage

>>> rtl/aes_key_sched.sv
module aes_key_sched
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = 10
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  block_t key,
    output block_t round_keys [ROUND_COUNT + 1]
);

    // Expand one round key per cycle; the user must change the key only while idle (unenforced).
    block_t rk_reg [ROUND_COUNT + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= ROUND_COUNT; r++)
                rk_reg[r] <= '0;
        end
        else
        begin
            rk_reg[0] <= key;
            for (int r = 1; r <= ROUND_COUNT; r++)
                rk_reg[r] <= next_round_key(rk_reg[r-1], RCON[r % 11]);
        end
    end

    assign round_keys = rk_reg;

    // load marks a fresh key; the chain settles without it, from rk_reg[0] up to rk_reg[ROUND_COUNT]
    logic unused_load;
    assign unused_load = load;

endmodule

>>> rtl/aes_round.sv
module aes_round
    import aes_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_inv,
    input  logic   last,
    input  block_t in_state,
    input  block_t round_key,
    output logic   out_valid,
    output logic   out_inv,
    output block_t out_state
);

    // Encrypt: sub, shift, mix, add.  Decrypt: shift, sub, add, mix.
    block_t mid_reg, mid_next;
    block_t key_reg;
    logic   valid_reg, inv_reg, last_reg;
    block_t res_reg, res_next;
    logic   rvalid_reg, rinv_reg;
    block_t t;

    always_comb
    begin
        if (in_inv)
            mid_next = sub_bytes(shift_rows(in_state, 1'b1), 1'b1);
        else
            mid_next = shift_rows(sub_bytes(in_state, 1'b0), 1'b0);
    end

    always_comb
    begin
        t = mid_reg ^ key_reg;
        if (inv_reg)
            res_next = last_reg ? t : mix_columns(t, 1'b1);
        else
            res_next = (last_reg ? mid_reg : mix_columns(mid_reg, 1'b0)) ^ key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= in_valid;
            rvalid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg  <= mid_next;
        key_reg  <= round_key;
        inv_reg  <= in_inv;
        last_reg <= last;
        res_reg  <= res_next;
        rinv_reg <= inv_reg;
    end

    assign out_valid = rvalid_reg;
    assign out_inv   = rinv_reg;
    assign out_state = res_reg;

endmodule

>>> rtl/aes128_block_cipher.sv
// AES-128 block cipher, encrypt and decrypt, fully pipelined.
// Key: write key_high at byte address 0 and key_low at 8 over the APB port
// (64-bit data). Round keys are expanded in a register chain, one round per
// cycle; busy stays high after reset and after every key write while the
// chain refills, and no item is taken during that time.
// Items: drive start with command (0 encrypt, 1 decrypt), block_high and
// block_low; an item is taken at any edge with start high and busy low.
// Pipeline: 1 input stage plus 2 stages per round, 10 rounds; done and the
// results are driven from the last round's registers. Throughput: one item
// per cycle while busy is low, set by the unrolled round pipeline (two
// register stages per round).
// Results: result_high/result_low are valid for exactly the one cycle in
// which done is high; the receiver cannot stall and must take them then.
// Reset: clears the key to all zeros, drops every item in flight and holds
// busy until the round keys of the zero key are in place.
module aes128_block_cipher
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
    localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
    localparam int         SETTLE_W      = $clog2(ROUND_COUNT + 2);

    logic [63:0] key_high_reg, key_low_reg;
    logic        wr_en;
    block_t      round_keys [ROUND_COUNT + 1];
    logic [SETTLE_W-1:0] settle_reg;

    assign pready = 1'b1;
    assign busy   = (settle_reg != '0);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_KEY_HIGH: key_high_reg <= pwdata;
                ADDR_KEY_LOW:  key_low_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // Hold off items until the last round key reflects the current key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(ROUND_COUNT + 1);
        else if (wr_en)
            settle_reg <= SETTLE_W'(ROUND_COUNT + 1);
        else if (settle_reg != '0)
            settle_reg <= settle_reg - 1'b1;
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_KEY_HIGH: prdata = key_high_reg;
            ADDR_KEY_LOW:  prdata = key_low_reg;
            default:       prdata = '0;
        endcase
    end

    aes_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_sched
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (wr_en),
        .key        ({key_high_reg, key_low_reg}),
        .round_keys (round_keys)
    );

    // Input stage: whitening with the first key of the chosen direction.
    logic   in_valid_reg, in_inv_reg;
    block_t in_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_inv_reg   <= command;
        in_state_reg <= {block_high, block_low} ^
                        (command == CMD_DECRYPT ? round_keys[ROUND_COUNT] : round_keys[0]);
    end

    logic   st_valid [ROUND_COUNT + 1];
    logic   st_inv   [ROUND_COUNT + 1];
    block_t st_state [ROUND_COUNT + 1];

    assign st_valid[0] = in_valid_reg;
    assign st_inv[0]   = in_inv_reg;
    assign st_state[0] = in_state_reg;

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        block_t rk;
        assign rk = st_inv[g] ? round_keys[ROUND_COUNT - 1 - g] : round_keys[g + 1];
        aes_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_inv    (st_inv[g]),
            .last      (g == ROUND_COUNT - 1),
            .in_state  (st_state[g]),
            .round_key (rk),
            .out_valid (st_valid[g+1]),
            .out_inv   (st_inv[g+1]),
            .out_state (st_state[g+1])
        );
    end

    assign done        = st_valid[ROUND_COUNT];
    assign result_high = st_state[ROUND_COUNT][127:64];
    assign result_low  = st_state[ROUND_COUNT][63:0];

    logic unused_inv;
    assign unused_inv = st_inv[ROUND_COUNT];

endmodule

>>> rtl/aes128_block_cipher_check.sv
module aes128_block_cipher_check
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready,
    input logic psel,
    input logic penable,
    input logic pwrite
);

    localparam int LATENCY = 21;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item not delivered after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_busy_on_rekey: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) |=> busy)
        else $error("item window open while round keys refill");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("apb access not ready");

endmodule

bind aes128_block_cipher aes128_block_cipher_check u_check
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .pready  (pready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite)
);
